>>> sv/ut2c_pkg.sv
package ut2c_pkg;

	localparam int unsigned ALU_W = 16;

	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	typedef enum logic [8:0] {
		ST_IDLE = 9'b0_0000_0001,
		ST_MUL  = 9'b0_0000_0010,
		ST_REM  = 9'b0_0000_0100,
		ST_WADD = 9'b0_0000_1000,
		ST_RADD = 9'b0_0001_0000,
		ST_YEAR = 9'b0_0010_0000,
		ST_MON  = 9'b0_0100_0000,
		ST_MSUB = 9'b0_1000_0000,
		ST_FIN  = 9'b1_0000_0000
	} state_t;

	localparam logic [1:0] DIV_SEC  = 2'd0;
	localparam logic [1:0] DIV_MIN  = 2'd1;
	localparam logic [1:0] DIV_HOUR = 2'd2;
	localparam logic [1:0] DIV_WDAY = 2'd3;

	// Day offset from the March-based year 1969 to the epoch day.
	localparam logic [ALU_W-1:0] EPOCH_DAY_OFFSET = 16'd337;
	localparam logic [ALU_W-1:0] WEEKDAY_OFFSET   = 16'd4;
	localparam logic [11:0]      FIRST_YEAR       = 12'd1969;
	localparam logic [11:0]      YEAR_LIMIT       = 12'd4095;

	function automatic logic [6:0] div_divisor(input logic [1:0] idx);
		logic [6:0] d;
		case (idx)
			DIV_SEC:  d = 7'd60;
			DIV_MIN:  d = 7'd60;
			DIV_HOUR: d = 7'd24;
			default:  d = 7'd7;
		endcase
		return d;
	endfunction

	// Reciprocal of each divisor scaled by two to the power of div_shift,
	// rounded up, so that the shifted product is the exact quotient.
	function automatic logic [31:0] div_recip(input logic [1:0] idx);
		logic [31:0] m;
		case (idx)
			DIV_SEC:  m = 32'h8888_8889;
			DIV_MIN:  m = 32'h8888_8889;
			DIV_HOUR: m = 32'hAAAA_AAAB;
			default:  m = 32'h9249_2493;
		endcase
		return m;
	endfunction

	function automatic logic [5:0] div_shift(input logic [1:0] idx);
		logic [5:0] s;
		case (idx)
			DIV_SEC:  s = 6'd37;
			DIV_MIN:  s = 6'd37;
			DIV_HOUR: s = 6'd36;
			default:  s = 6'd34;
		endcase
		return s;
	endfunction

	// Start of month m of a March-based year, 367*m/12.
	function automatic logic [8:0] month_start(input logic [3:0] m);
		logic [8:0] s;
		case (m)
			4'd1:    s = 9'd30;
			4'd2:    s = 9'd61;
			4'd3:    s = 9'd91;
			4'd4:    s = 9'd122;
			4'd5:    s = 9'd152;
			4'd6:    s = 9'd183;
			4'd7:    s = 9'd214;
			4'd8:    s = 9'd244;
			4'd9:    s = 9'd275;
			4'd10:   s = 9'd305;
			4'd11:   s = 9'd336;
			4'd12:   s = 9'd367;
			default: s = 9'd0;
		endcase
		return s;
	endfunction

endpackage

>>> sv/ut2c_alu.sv
module ut2c_alu (
	input  ut2c_pkg::alu_op_t            op,
	input  logic [ut2c_pkg::ALU_W-1:0]   a,
	input  logic [ut2c_pkg::ALU_W-1:0]   b,
	output logic [ut2c_pkg::ALU_W-1:0]   res,
	output logic                         carry
);
	import ut2c_pkg::*;

	logic [ALU_W:0]   sum;
	logic [ALU_W-1:0] b_in;

	// On subtract the carry out is set when a >= b.
	assign b_in  = (op == ALU_SUB) ? ~b : b;
	assign sum   = {1'b0, a} + {1'b0, b_in} + {{ALU_W{1'b0}}, (op == ALU_SUB)};
	assign res   = sum[ALU_W-1:0];
	assign carry = sum[ALU_W];

endmodule

>>> sv/unix_time_to_calendar.sv
// Converts epoch seconds to a UTC calendar date and time, one word at a time.
// The year search on the shared adder steps over Y years (0..136), and the month
// search then steps over M months (0..11).
// A new word is taken the cycle after the result is loaded.
// Reset (arst_n low) clears the sequencer and the output valid at once.
module unix_time_to_calendar (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] epoch_seconds,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [5:0]  second,
	output logic [5:0]  minute,
	output logic [4:0]  hour,
	output logic [2:0]  weekday,
	output logic [11:0] year,
	output logic [3:0]  month,
	output logic [4:0]  day_of_month
);
	import ut2c_pkg::*;

	state_t            state_q;
	logic [31:0]       q_q;
	logic [63:0]       prod_q;
	logic [1:0]        idx_q;
	logic [15:0]       days_q;
	logic [15:0]       r_q;
	logic [11:0]       yr_q;
	logic [1:0]        c4_q;
	logic [6:0]        c100_q;
	logic [8:0]        c400_q;
	logic [3:0]        mon_q;
	logic [5:0]        sec_q;
	logic [5:0]        min_q;
	logic [4:0]        hr_q;
	logic [2:0]        wday_q;

	logic              out_valid_q;
	logic [5:0]        second_q;
	logic [5:0]        minute_q;
	logic [4:0]        hour_q;
	logic [2:0]        weekday_q;
	logic [11:0]       year_q;
	logic [3:0]        month_q;
	logic [4:0]        mday_q;

	alu_op_t           alu_op;
	logic [ALU_W-1:0]  alu_a;
	logic [ALU_W-1:0]  alu_b;
	logic [ALU_W-1:0]  alu_res;
	logic              alu_carry;

	logic [63:0]       mul_prod;
	logic [63:0]       quot_wide;
	logic [12:0]       qd_low;
	logic [5:0]        nrem;
	logic [31:0]       quot;
	logic              leap;
	logic              year_step;
	logic              mon_step;
	logic              out_load;
	logic [3:0]        mon_next;
	logic              in_acc;

	ut2c_alu u_alu (
		.op    (alu_op),
		.a     (alu_a),
		.b     (alu_b),
		.res   (alu_res),
		.carry (alu_carry)
	);

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;

	// Year n = yr + 1 is a leap year when its residues say so.
	assign leap = ((c4_q == 2'd0) && (c100_q != 7'd0)) || (c400_q == 9'd0);

	always_comb begin
		alu_op = ALU_SUB;
		alu_a  = '0;
		alu_b  = '0;
		case (state_q)
			ST_WADD: begin
				alu_op = ALU_ADD;
				alu_a  = days_q;
				alu_b  = WEEKDAY_OFFSET;
			end
			ST_RADD: begin
				alu_op = ALU_ADD;
				alu_a  = days_q;
				alu_b  = EPOCH_DAY_OFFSET;
			end
			ST_YEAR: begin
				alu_a = r_q;
				alu_b = 16'd365 + {15'b0, leap};
			end
			ST_MON: begin
				alu_a = r_q;
				alu_b = {7'b0, month_start(mon_q + 4'd1)};
			end
			ST_MSUB: begin
				alu_a = r_q;
				alu_b = {7'b0, month_start(mon_q)};
			end
			default: begin
				alu_op = ALU_SUB;
			end
		endcase
	end

	// Division by a constant: the product with the reciprocal is registered,
	// then the quotient is taken from its top bits on the next cycle. The
	// remainder is below 64, so only the low six bits of q * d are needed.
	assign mul_prod  = {32'b0, q_q} * {32'b0, div_recip(idx_q)};
	assign quot_wide = prod_q >> div_shift(idx_q);
	assign quot      = quot_wide[31:0];
	assign qd_low    = {7'b0, quot[5:0]} * {6'b0, div_divisor(idx_q)};
	assign nrem      = q_q[5:0] - qd_low[5:0];

	// Step on while the remaining days exceed this year's length plus 30 and yr is below YEAR_LIMIT.
	assign year_step = alu_carry && (alu_res > 16'd30) && (yr_q != YEAR_LIMIT);
	assign mon_step  = (mon_q < 4'd12) && alu_carry && (alu_res != 16'd0);

	assign out_load = (state_q == ST_FIN) && (!out_valid_q || !out_stall);
	assign mon_next = mon_q + 4'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (in_acc) state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_REM;
				ST_REM: begin
					if (idx_q == DIV_HOUR) state_q <= ST_WADD;
					else if (idx_q == DIV_WDAY) state_q <= ST_RADD;
					else state_q <= ST_MUL;
				end
				ST_WADD: state_q <= ST_MUL;
				ST_RADD: state_q <= ST_YEAR;
				ST_YEAR: if (!year_step) state_q <= ST_MON;
				ST_MON:  if (!mon_step) state_q <= ST_MSUB;
				ST_MSUB: state_q <= ST_FIN;
				ST_FIN:  if (out_load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				q_q   <= epoch_seconds;
				idx_q <= DIV_SEC;
			end
			ST_MUL: prod_q <= mul_prod;
			ST_REM: begin
				q_q   <= quot;
				idx_q <= idx_q + 2'd1;
				case (idx_q)
					DIV_SEC:  sec_q <= nrem;
					DIV_MIN:  min_q <= nrem;
					DIV_HOUR: begin
						hr_q   <= nrem[4:0];
						days_q <= quot[15:0];
					end
					default: begin
						wday_q <= nrem[2:0];
					end
				endcase
			end
			ST_WADD: q_q <= {16'b0, alu_res};
			ST_RADD: begin
				r_q    <= alu_res;
				yr_q   <= FIRST_YEAR;
				c4_q   <= 2'd2;
				c100_q <= 7'd70;
				c400_q <= 9'd370;
			end
			ST_YEAR: begin
				if (year_step) begin
					r_q    <= alu_res;
					yr_q   <= yr_q + 12'd1;
					c4_q   <= c4_q + 2'd1;
					c100_q <= (c100_q == 7'd99) ? 7'd0 : c100_q + 7'd1;
					c400_q <= (c400_q == 9'd399) ? 9'd0 : c400_q + 9'd1;
				end else begin
					mon_q <= 4'd1;
				end
			end
			ST_MON: if (mon_step) mon_q <= mon_next;
			ST_MSUB: r_q <= alu_res;
			default: begin
				r_q <= r_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// March-based months 11 and 12 are January and February of the next year.
	always_ff @(posedge clk) begin
		if (out_load) begin
			second_q  <= sec_q;
			minute_q  <= min_q;
			hour_q    <= hr_q;
			weekday_q <= wday_q;
			mday_q    <= r_q[4:0];
			if (mon_next > 4'd11) begin
				month_q <= mon_next - 4'd12;
				year_q  <= yr_q + 12'd1;
			end else begin
				month_q <= mon_next;
				year_q  <= yr_q;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign second       = second_q;
	assign minute       = minute_q;
	assign hour         = hour_q;
	assign weekday      = weekday_q;
	assign year         = year_q;
	assign month        = month_q;
	assign day_of_month = mday_q;

	a_start_div: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_MUL))
		else $error("accepted word did not start the divider");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REM) |-> ({1'b0, nrem} < div_divisor(idx_q)))
		else $error("divider remainder out of range");

	a_year_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_YEAR) |-> (yr_q <= 12'd2106))
		else $error("year search ran past the input range");

	a_mon_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MSUB) |-> ((mon_q >= 4'd1) && (mon_q <= 4'd12)))
		else $error("month search left its range");

	a_busy_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid_q && !in_stall)
		else $error("result load did not free the input");

endmodule

>>> test/unix_time_to_calendar_tb.sv
typedef struct {
	logic [31:0] epoch;
	logic [5:0]  second;
	logic [5:0]  minute;
	logic [4:0]  hour;
	logic [2:0]  weekday;
	logic [11:0] year;
	logic [3:0]  month;
	logic [4:0]  day_of_month;
} calendar_t;

class calendar_scoreboard;
	calendar_t   expected_dates[$];
	int unsigned mismatches;
	int unsigned words_converted;
	int unsigned year_lo;
	int unsigned year_hi;

	function new();
		mismatches = 0;
		words_converted = 0;
		year_lo = 4095;
		year_hi = 0;
	endfunction

	// Days from the start of the era to March 1 of year y.
	function int unsigned days_to_march(int unsigned y);
		return y * 365 + y / 4 - y / 100 + y / 400;
	endfunction

	function calendar_t convert_epoch(logic [31:0] epoch);
		calendar_t   c;
		int unsigned t;
		int unsigned days;
		int unsigned yr;
		int unsigned mon;
		c.epoch = epoch;
		t = epoch;
		c.second = 6'(t % 60);
		t = t / 60;
		c.minute = 6'(t % 60);
		t = t / 60;
		c.hour = 5'(t % 24);
		t = t / 24;
		c.weekday = 3'((t + 4) % 7);
		days = t + 719499;
		// Years run from March so that the leap day closes the year.
		yr = 1969;
		while (yr < 4095 && days > days_to_march(yr + 1) + 30)
			yr++;
		days = days - days_to_march(yr);
		mon = 1;
		while (mon < 12 && days > (367 * (mon + 1)) / 12)
			mon++;
		days = days - (367 * mon) / 12;
		mon++;
		if (mon > 11) begin
			mon = mon - 12;
			yr++;
		end
		c.year = 12'(yr);
		c.month = 4'(mon);
		c.day_of_month = 5'(days);
		return c;
	endfunction

	function void note_word(logic [31:0] epoch);
		expected_dates.push_back(convert_epoch(epoch));
	endfunction

	task report(string what, int unsigned got, int unsigned want, logic [31:0] epoch);
		$display("ERROR at %0t: epoch %0d: %s got %0d expected %0d",
			$time, epoch, what, got, want);
		mismatches++;
	endtask

	task check_result(calendar_t got);
		calendar_t want;
		if (expected_dates.size() == 0) begin
			report("result with no word pending, year", 32'(got.year), 0, 0);
		end else begin
			want = expected_dates.pop_front();
			if (got.second !== want.second)
				report("second", 32'(got.second), 32'(want.second), want.epoch);
			if (got.minute !== want.minute)
				report("minute", 32'(got.minute), 32'(want.minute), want.epoch);
			if (got.hour !== want.hour)
				report("hour", 32'(got.hour), 32'(want.hour), want.epoch);
			if (got.weekday !== want.weekday)
				report("weekday", 32'(got.weekday), 32'(want.weekday), want.epoch);
			if (got.year !== want.year)
				report("year", 32'(got.year), 32'(want.year), want.epoch);
			if (got.month !== want.month)
				report("month", 32'(got.month), 32'(want.month), want.epoch);
			if (got.day_of_month !== want.day_of_month)
				report("day_of_month", 32'(got.day_of_month), 32'(want.day_of_month),
					want.epoch);
			words_converted++;
			if (32'(want.year) < year_lo)
				year_lo = 32'(want.year);
			if (32'(want.year) > year_hi)
				year_hi = 32'(want.year);
		end
	endtask
endclass

module unix_time_to_calendar_tb;
	localparam int unsigned RANDOM_WORDS = 450;
	localparam int unsigned QUIET_WORDS = 60;
	localparam int unsigned DRAIN_CYCLES = 300;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [31:0] epoch_seconds;
	logic        out_valid;
	logic        out_stall;
	logic [5:0]  second;
	logic [5:0]  minute;
	logic [4:0]  hour;
	logic [2:0]  weekday;
	logic [11:0] year;
	logic [3:0]  month;
	logic [4:0]  day_of_month;

	calendar_scoreboard dates;
	bit                 quiet;

	unix_time_to_calendar DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.epoch_seconds(epoch_seconds),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.second       (second),
		.minute       (minute),
		.hour         (hour),
		.weekday      (weekday),
		.year         (year),
		.month        (month),
		.day_of_month (day_of_month)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#8_000_000;
		$display("timeout: results still outstanding");
		$display("** unix_time_to_calendar: FAILED **");
		$finish;
	end

	task send_word(logic [31:0] epoch);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid <= 1'b1;
		epoch_seconds <= epoch;
		do
			@(posedge clk);
		while (in_stall);
		dates.note_word(epoch);
	endtask

	function logic [31:0] random_epoch();
		int unsigned pick;
		logic [31:0] day;
		pick = $urandom_range(0, 9);
		if (pick < 4)
			return $urandom;
		if (pick < 7) begin
			day = $urandom_range(0, 49709);
			return day * 86400 + $urandom_range(0, 86399);
		end
		// Straddle a midnight so the date rollover gets exercised.
		day = $urandom_range(1, 49710);
		return day * 86400 - $urandom_range(0, 1);
	endfunction

	// Receiver back-pressure in bursts, switched off for the quiet tail.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		calendar_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.epoch = 32'd0;
			got.second = second;
			got.minute = minute;
			got.hour = hour;
			got.weekday = weekday;
			got.year = year;
			got.month = month;
			got.day_of_month = day_of_month;
			dates.check_result(got);
		end
	end

	initial begin
		logic [31:0] corner_words[];
		dates = new();
		quiet = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		epoch_seconds = 32'd0;
		corner_words = '{
			32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
			32'd5097599, 32'd5097600,
			32'd68169600, 32'd94694399,
			32'd951782399, 32'd951782400, 32'd951868800,
			32'd4107542399, 32'd4107542400,
			32'h7FFFFFFF, 32'h80000000, 32'hAAAAAAAA, 32'h55555555,
			32'hFFFFFFFE, 32'hFFFFFFFF
		};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (corner_words[i])
			send_word(corner_words[i]);
		for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
			if (n == RANDOM_WORDS - QUIET_WORDS)
				quiet = 1'b1;
			send_word(random_epoch());
		end
		in_valid <= 1'b0;

		while (dates.expected_dates.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Converted %0d words: corner dates, leap and century days, random epochs.",
			dates.words_converted);
		$display("Years seen %0d to %0d, with %0d mismatches.",
			dates.year_lo, dates.year_hi, dates.mismatches);
		if (dates.mismatches == 0)
			$display("** unix_time_to_calendar: PASSED **");
		else
			$display("** unix_time_to_calendar: FAILED **");
		$finish;
	end
endmodule

>>> sim.f
sv/ut2c_pkg.sv
sv/ut2c_alu.sv
sv/unix_time_to_calendar.sv
test/unix_time_to_calendar_tb.sv
